>>> rtl/cosim_pkg.sv
package cosim_pkg;

    // default sizes of the element, accumulator and score fraction
    localparam int ELEM_WIDTH_DEF    = 16;
    localparam int ACC_WIDTH_DEF     = 48;
    localparam int OUT_FRAC_BITS_DEF = 16;

    // datapath word of the root and divide unit
    localparam int WORD_W = 64;
    // shared multiplier operand width (signed elements up to 32 bits, unsigned roots)
    localparam int MUL_W  = 33;
    localparam int ROOT_W = 32;
    // normalization shift count, at most 31 double-bit steps
    localparam int K_W    = 5;
    // quotient register, cap at 2^40 plus one shifted bit
    localparam int QUOT_W = 42;

    localparam logic [WORD_W-1:0] NORM_LIMIT    = WORD_W'(1) << 61;
    localparam logic [WORD_W-1:0] SQRT_BIT_INIT = WORD_W'(1) << 62;
    localparam logic [QUOT_W-1:0] QUOT_CAP      = QUOT_W'(1) << 40;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MAC   = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_NORM  = 8'b0000_1000,
        ST_SQRT  = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } cosim_state_t;

    typedef enum logic [1:0] {
        PH_AB = 2'd0,
        PH_AA = 2'd1,
        PH_BB = 2'd2,
        PH_LAST_ADD = 2'd3
    } cosim_phase_t;

endpackage

>>> rtl/cosine_similarity_core.sv
// cosine similarity / distance engine. one element pair (s_elem_a, s_elem_b) is one
// input word; s_last_elem marks the final pair of the two vectors. every pair is
// multiplied three times on a single shared multiplier (a*b, a*a, b*b) and added to
// three saturating accumulators, so s_ready stays low while a pair is multiplied and
// added, and the next pair is accepted only back in idle. after the last pair the same
// multiplier and a shared normalize / bit-pair square-root unit run over both sums
// of squares, then a restoring divider produces one quotient bit a cycle. the last
// pair also passes the zero check, the root product and the result load, plus any
// wait for m_ready while the output register is full. ka, kb (0..31) are the
// double-bit normalize shifts of the two sums and lengthen the divide; the divider
// loop dominates. score is signed with OUT_FRAC_BITS fraction bits:
// cosine similarity when distance_mode is 0, one minus it when 1, saturated. when
// either vector is all zero the score is 0 (or 1.0 as distance) and m_zero_norm is
// set. the result sits in an output register, so the next vector starts streaming
// while a result waits. cfg_wr_en/cfg_wr_data write distance_mode and are meant
// to be used while the block is idle.
module cosine_similarity_core
    import cosim_pkg::*;
#(
    parameter int ELEM_WIDTH    = ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH     = ACC_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ELEM_WIDTH-1:0]  s_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]  s_elem_b,
    input  logic                          s_last_elem,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_FRAC_BITS+2:0] m_score,
    output logic                          m_zero_norm
);

    localparam int OUT_W  = OUT_FRAC_BITS + 3;
    // accumulator plus product, one guard bit
    localparam int SUM_W  = WORD_W + 1;
    // score arithmetic width, rounded quotient is below 2^40
    localparam int SC_W   = QUOT_W + 3;
    // divider iteration count: 64 dividend bits plus the fraction bits, one rounding bit and the norm shifts
    localparam int DIV_BASE = WORD_W + OUT_FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(DIV_BASE + 2 * ((1 << K_W) - 1) + 1);

    localparam logic signed [SUM_W-1:0] ACC_HI =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [SC_W-1:0] ONE_SC  = SC_W'(1) << OUT_FRAC_BITS;
    localparam logic signed [SC_W-1:0] OUT_MAX =
        {{(SC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SC_W-1:0] OUT_MIN = ~OUT_MAX;

    // saturating add of a product into an accumulator
    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [WORD_W-1:0]    p
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(p);
        if (s > ACC_HI) begin
            return ACC_HI[ACC_WIDTH-1:0];
        end else if (s < ACC_LO) begin
            return ACC_LO[ACC_WIDTH-1:0];
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    cosim_state_t                  state_reg, state_next;
    cosim_phase_t                  phase_reg, phase_next;
    logic signed [ELEM_WIDTH-1:0]  elem_a_reg, elem_a_next;
    logic signed [ELEM_WIDTH-1:0]  elem_b_reg, elem_b_next;
    logic                          last_reg, last_next;
    logic signed [WORD_W-1:0]      prod_reg, prod_next;
    logic signed [ACC_WIDTH-1:0]   dot_reg, dot_next;
    logic signed [ACC_WIDTH-1:0]   sqa_reg, sqa_next;
    logic signed [ACC_WIDTH-1:0]   sqb_reg, sqb_next;
    logic                          zero_reg, zero_next;
    logic [WORD_W-1:0]             work_reg, work_next;
    logic [WORD_W-1:0]             root_reg, root_next;
    logic [WORD_W-1:0]             bit_reg, bit_next;
    logic [K_W-1:0]                k_reg, k_next;
    logic                          sel_b_reg, sel_b_next;
    logic [ROOT_W-1:0]             ra_reg, ra_next;
    logic [K_W-1:0]                ka_reg, ka_next;
    logic [WORD_W-1:0]             rem_reg, rem_next;
    logic [QUOT_W-1:0]             quot_reg, quot_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          mode_reg, mode_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]       m_score_reg, m_score_next;
    logic                          m_zero_norm_reg, m_zero_norm_next;

    // shared multiplier
    logic signed [MUL_W-1:0]       mul_x, mul_y;
    logic signed [2*MUL_W-1:0]     mul_p;

    // square-root step
    logic [WORD_W-1:0]             sq_trial;
    logic                          sq_take;
    logic [WORD_W-1:0]             sq_root;

    // divider step
    logic [WORD_W-1:0]             div_r;
    logic                          div_ge;
    logic [QUOT_W-1:0]             div_q;

    // dividend magnitude
    logic signed [WORD_W-1:0]      dot_ext;
    logic [WORD_W-1:0]             dot_mag;

    // score formation
    logic [QUOT_W:0]               quot_inc;
    logic signed [SC_W-1:0]        cos_mag, cos_val, score_w;
    logic                          out_load;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_score     = m_score_reg;
    assign m_zero_norm = m_zero_norm_reg;

    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // operand select: element products while streaming, root product at the end
    always_comb begin
        mul_x = MUL_W'(elem_a_reg);
        mul_y = MUL_W'(elem_b_reg);
        if (state_reg == ST_MUL) begin
            mul_x = $signed({1'b0, ra_reg});
            mul_y = $signed({1'b0, root_reg[ROOT_W-1:0]});
        end else begin
            case (phase_reg)
                PH_AA: begin
                    mul_x = MUL_W'(elem_a_reg);
                    mul_y = MUL_W'(elem_a_reg);
                end
                PH_BB: begin
                    mul_x = MUL_W'(elem_b_reg);
                    mul_y = MUL_W'(elem_b_reg);
                end
                default: begin
                    mul_x = MUL_W'(elem_a_reg);
                    mul_y = MUL_W'(elem_b_reg);
                end
            endcase
        end
    end

    assign mul_p = mul_x * mul_y;

    assign sq_trial = root_reg + bit_reg;
    assign sq_take  = (work_reg >= sq_trial);
    assign sq_root  = sq_take ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    assign div_r  = {rem_reg[WORD_W-2:0], work_reg[WORD_W-1]};
    assign div_ge = (div_r >= prod_reg);
    assign div_q  = {quot_reg[QUOT_W-2:0], div_ge};

    assign dot_ext = WORD_W'(dot_reg);
    assign dot_mag = dot_reg[ACC_WIDTH-1] ? (WORD_W'(0) - dot_ext) : dot_ext;

    // round half away from zero, apply sign and mode, saturate
    always_comb begin
        quot_inc = {1'b0, quot_reg} + (QUOT_W+1)'(1);
        cos_mag  = SC_W'(quot_inc[QUOT_W:1]);
        cos_val  = dot_reg[ACC_WIDTH-1] ? -cos_mag : cos_mag;
        score_w  = mode_reg ? (ONE_SC - cos_val) : cos_val;
        if (score_w > OUT_MAX) begin
            score_w = OUT_MAX;
        end else if (score_w < OUT_MIN) begin
            score_w = OUT_MIN;
        end
    end

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        elem_a_next      = elem_a_reg;
        elem_b_next      = elem_b_reg;
        last_next        = last_reg;
        prod_next        = prod_reg;
        dot_next         = dot_reg;
        sqa_next         = sqa_reg;
        sqb_next         = sqb_reg;
        zero_next        = zero_reg;
        work_next        = work_reg;
        root_next        = root_reg;
        bit_next         = bit_reg;
        k_next           = k_reg;
        sel_b_next       = sel_b_reg;
        ra_next          = ra_reg;
        ka_next          = ka_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        mode_next        = cfg_wr_en ? cfg_wr_data : mode_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_score_next     = m_score_reg;
        m_zero_norm_next = m_zero_norm_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    elem_a_next = s_elem_a;
                    elem_b_next = s_elem_b;
                    last_next   = s_last_elem;
                    phase_next  = PH_AB;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC: begin
                // product registered in one phase, added in the next
                prod_next = mul_p[WORD_W-1:0];
                case (phase_reg)
                    PH_AB: begin
                        phase_next = PH_AA;
                    end
                    PH_AA: begin
                        dot_next   = sat_add(dot_reg, prod_reg);
                        phase_next = PH_BB;
                    end
                    PH_BB: begin
                        sqa_next   = sat_add(sqa_reg, prod_reg);
                        phase_next = PH_LAST_ADD;
                    end
                    default: begin
                        sqb_next   = sat_add(sqb_reg, prod_reg);
                        phase_next = PH_AB;
                        state_next = last_reg ? ST_CHECK : ST_IDLE;
                    end
                endcase
            end
            ST_CHECK: begin
                if (!(sqa_reg > 0) || !(sqb_reg > 0)) begin
                    zero_next  = 1'b1;
                    quot_next  = '0;
                    state_next = ST_FIN;
                end else begin
                    zero_next  = 1'b0;
                    work_next  = WORD_W'($unsigned(sqa_reg));
                    k_next     = '0;
                    sel_b_next = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // two bits at a time until the value reaches 2^61
                if (work_reg < NORM_LIMIT) begin
                    work_next = work_reg << 2;
                    k_next    = k_reg + K_W'(1);
                end else begin
                    root_next  = '0;
                    bit_next   = SQRT_BIT_INIT;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sq_take) begin
                    work_next = work_reg - sq_trial;
                end
                root_next = sq_root;
                bit_next  = bit_reg >> 2;
                if (bit_reg[0]) begin
                    if (!sel_b_reg) begin
                        ra_next    = sq_root[ROOT_W-1:0];
                        ka_next    = k_reg;
                        work_next  = WORD_W'($unsigned(sqb_reg));
                        k_next     = '0;
                        sel_b_next = 1'b1;
                        state_next = ST_NORM;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // divisor is the product of the two roots
                prod_next  = mul_p[WORD_W-1:0];
                work_next  = dot_mag;
                rem_next   = '0;
                quot_next  = '0;
                cnt_next   = CNT_W'(DIV_BASE) + CNT_W'(ka_reg) + CNT_W'(k_reg);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                work_next = work_reg << 1;
                rem_next  = div_ge ? (div_r - prod_reg) : div_r;
                quot_next = (div_q > QUOT_CAP) ? QUOT_CAP : div_q;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    m_valid_next     = 1'b1;
                    m_score_next     = score_w[OUT_W-1:0];
                    m_zero_norm_next = zero_reg;
                    dot_next         = '0;
                    sqa_next         = '0;
                    sqb_next         = '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_AB;
            dot_reg     <= '0;
            sqa_reg     <= '0;
            sqb_reg     <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            dot_reg     <= dot_next;
            sqa_reg     <= sqa_next;
            sqb_reg     <= sqb_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elem_a_reg      <= elem_a_next;
        elem_b_reg      <= elem_b_next;
        last_reg        <= last_next;
        prod_reg        <= prod_next;
        zero_reg        <= zero_next;
        work_reg        <= work_next;
        root_reg        <= root_next;
        bit_reg         <= bit_next;
        k_reg           <= k_next;
        sel_b_reg       <= sel_b_next;
        ra_reg          <= ra_next;
        ka_reg          <= ka_next;
        rem_reg         <= rem_next;
        quot_reg        <= quot_next;
        cnt_reg         <= cnt_next;
        m_score_reg     <= m_score_next;
        m_zero_norm_reg <= m_zero_norm_next;
    end

`ifndef SYNTHESIS
    // a zero-norm result is either zero or exactly 1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_norm) |->
            (m_score == OUT_W'(0) || m_score == ONE_SC[OUT_W-1:0]))
        else $error("zero-norm word with unexpected score");

    // accumulators are empty once a result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (dot_reg == '0 && sqa_reg == '0 && sqb_reg == '0))
        else $error("accumulators not cleared after result");

    // quotient never passes the cap during the divide
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> (quot_reg <= QUOT_CAP))
        else $error("quotient above cap");

    // an accepted word always starts the multiply sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MAC && phase_reg == PH_AB))
        else $error("accepted word did not start multiply");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // sizes follow the block's defaults
    localparam int ELEM_W  = cosim_pkg::ELEM_WIDTH_DEF;
    localparam int ACC_W   = cosim_pkg::ACC_WIDTH_DEF;
    localparam int FRAC_W  = cosim_pkg::OUT_FRAC_BITS_DEF;
    localparam int SCORE_W = FRAC_W + 3;

    // saturation bounds of the accumulators and of the score
    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -ACC_HI - 1;
    localparam longint SCORE_HI = (longint'(1) <<< (SCORE_W - 1)) - 1;
    localparam longint SCORE_LO = -SCORE_HI - 1;
    // 1.0 in score units
    localparam longint ONE_Q    = longint'(1) <<< FRAC_W;
    // ceiling on the doubled quotient before rounding
    localparam logic [127:0] RATIO_CAP = 128'd1 << 40;
    // sums of squares are scaled up until they reach this
    localparam logic [63:0] NORM_FLOOR = 64'd1 << 61;

    // length of the long vector of max-size pairs
    localparam int LONG_PAIRS    = 40;
    localparam int SETTLE_CYCLES = 16;
    localparam longint RUN_LIMIT_NS = 10_000_000;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      zero_norm;
    } score_t;

    // how the elements of a random vector are drawn
    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_EDGE,
        FILL_MATCHED,
        FILL_ONE_ZERO
    } fill_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // block ports, all inputs known from time zero
    logic                     cfg_wr_en   = 1'b0;
    logic                     cfg_wr_data = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic signed [ELEM_W-1:0] s_elem_a    = '0;
    logic signed [ELEM_W-1:0] s_elem_b    = '0;
    logic                     s_last_elem = 1'b0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic signed [SCORE_W-1:0] m_score;
    logic                     m_zero_norm;

    cosine_similarity_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_elem_a    (s_elem_a),
        .s_elem_b    (s_elem_b),
        .s_last_elem (s_last_elem),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_score     (m_score),
        .m_zero_norm (m_zero_norm)
    );

    // predictor state: running sums of the open vector and the mode register
    longint dot_sum  = 0;
    longint sq_a_sum = 0;
    longint sq_b_sum = 0;
    logic   mode_bit = 1'b0;

    // scores still owed by the block, oldest first
    score_t expected_scores[$];

    // idling switches for the two sides
    bit in_idle_en   = 1'b1;
    bit out_stall_en = 1'b1;

    int errors       = 0;
    int pairs_sent   = 0;
    int vectors_sent = 0;
    int zero_vectors = 0;
    int results_seen = 0;
    int mode_writes  = 0;

    // add one product to an accumulator, clamped to the accumulator range
    function automatic longint sat_accumulate(input longint acc, input longint prod);
        longint sum;
        sum = acc + prod;
        if (sum > ACC_HI) return ACC_HI;
        if (sum < ACC_LO) return ACC_LO;
        return sum;
    endfunction

    // floor of the square root, one result bit at a time from the top
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    // root of s * 4^shift, with s scaled into [2^61, 2^63)
    function automatic logic [63:0] scaled_root(input logic [63:0] s, output int shift);
        shift = 0;
        while (s < NORM_FLOOR) begin
            s = s << 2;
            shift++;
        end
        return int_sqrt(s);
    endfunction

    // score of the vector held in the running sums
    function automatic score_t vector_score();
        score_t      res;
        int          ka;
        int          kb;
        logic [63:0] ra;
        logic [63:0] rb;
        logic [63:0] den;
        logic [63:0] mag;
        logic [127:0] quot;
        longint      cos_q;
        longint      val;
        res.zero_norm = 1'b0;
        cos_q = 0;
        if (sq_a_sum <= 0 || sq_b_sum <= 0) begin
            res.zero_norm = 1'b1;
        end else begin
            ra  = scaled_root(sq_a_sum, ka);
            rb  = scaled_root(sq_b_sum, kb);
            den = ra * rb;
            mag = (dot_sum < 0) ? -dot_sum : dot_sum;
            // one extra fraction bit for rounding half away from zero
            quot = ({64'd0, mag} << (FRAC_W + 1 + ka + kb)) / {64'd0, den};
            if (quot > RATIO_CAP) quot = RATIO_CAP;
            cos_q = longint'((quot + 128'd1) >> 1);
            if (dot_sum < 0) cos_q = -cos_q;
        end
        val = mode_bit ? ONE_Q - cos_q : cos_q;
        if (val > SCORE_HI) val = SCORE_HI;
        if (val < SCORE_LO) val = SCORE_LO;
        res.score = val[SCORE_W-1:0];
        return res;
    endfunction

    // fold one accepted pair into the sums; the last pair closes the vector
    function automatic void absorb_pair(input logic signed [ELEM_W-1:0] a,
                                        input logic signed [ELEM_W-1:0] b,
                                        input logic is_last);
        longint ea;
        longint eb;
        score_t res;
        ea = a;
        eb = b;
        dot_sum  = sat_accumulate(dot_sum, ea * eb);
        sq_a_sum = sat_accumulate(sq_a_sum, ea * ea);
        sq_b_sum = sat_accumulate(sq_b_sum, eb * eb);
        if (is_last) begin
            res = vector_score();
            expected_scores.push_back(res);
            vectors_sent++;
            if (res.zero_norm) zero_vectors++;
            dot_sum  = 0;
            sq_a_sum = 0;
            sq_b_sum = 0;
        end
    endfunction

    // result side: random back-pressure and a check of every result word
    always @(posedge aclk) begin
        score_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_scores.size() == 0) begin
                $display("%0t: unexpected result word, score %0d zero_norm %0b",
                         $time, m_score, m_zero_norm);
                errors++;
            end else begin
                want = expected_scores.pop_front();
                results_seen++;
                if (m_score !== want.score) begin
                    $display("%0t: score mismatch, expected %0d, actual %0d",
                             $time, $signed(want.score), m_score);
                    errors++;
                end
                if (m_zero_norm !== want.zero_norm) begin
                    $display("%0t: zero_norm mismatch, expected %0b, actual %0b",
                             $time, want.zero_norm, m_zero_norm);
                    errors++;
                end
            end
        end
        m_ready <= !out_stall_en || ($urandom_range(99) >= 32);
    end

    // send one element pair word, with a random gap in front when idling is on
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic is_last);
        if (in_idle_en) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_elem_a    <= a;
        s_elem_b    <= b;
        s_last_elem <= is_last;
        do @(posedge aclk); while (!s_ready);
        absorb_pair(a, b, is_last);
        pairs_sent++;
    endtask

    // hold off the sender until every owed result is out and the block is quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mode register write, only ever issued while the block is idle
    task automatic write_mode(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_bit = value;
        mode_writes++;
    endtask

    function automatic logic signed [ELEM_W-1:0] small_elem();
        return ELEM_W'($urandom_range(8)) - ELEM_W'(4);
    endfunction

    function automatic logic signed [ELEM_W-1:0] edge_elem();
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh8001;
            2:       return 16'shffff;
            3:       return 16'sh0000;
            4:       return 16'sh0001;
            default: return 16'sh7fff;
        endcase
    endfunction

    // mostly short vectors, a few long ones
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(6, 1);
        if (roll < 95) return $urandom_range(32, 7);
        return $urandom_range(120, 33);
    endfunction

    function automatic fill_t pick_fill();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return FILL_FULL;
        if (roll < 50) return FILL_SMALL;
        if (roll < 65) return FILL_EDGE;
        if (roll < 90) return FILL_MATCHED;
        return FILL_ONE_ZERO;
    endfunction

    // one whole vector pair; matched vectors give scores near +1 or -1
    task automatic send_vector(input int len, input fill_t fill);
        int rel;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        rel = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_FULL: begin
                    a = ELEM_W'($urandom);
                    b = ELEM_W'($urandom);
                end
                FILL_SMALL: begin
                    a = small_elem();
                    b = small_elem();
                end
                FILL_EDGE: begin
                    a = edge_elem();
                    b = edge_elem();
                end
                FILL_MATCHED: begin
                    a = ($urandom_range(1) == 0) ? ELEM_W'($urandom) : small_elem();
                    case (rel)
                        0:       b = a;
                        1:       b = -a;
                        default: b = a + small_elem();
                    endcase
                end
                default: begin
                    // one side stays all zero
                    a = (rel == 0) ? ELEM_W'(0) : ELEM_W'($urandom);
                    b = (rel == 0) ? ELEM_W'($urandom) : ELEM_W'(0);
                end
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // similarity mode: extreme elements, zero vectors, orthogonal vectors
    task automatic test_similarity_edges();
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh0001, 16'shffff, 1'b1);
        send_pair(16'shffff, 16'sh8000, 1'b1);
        // zero norm on either side and on both
        send_pair(16'sh0000, 16'sh0005, 1'b1);
        send_pair(-16'sd7, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        // an orthogonal vector and a strongly negative one, both norms nonzero
        send_pair(16'sh0001, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'sh0001, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sd12345, 16'shffff, 1'b1);
        // leading zero pairs do not disturb the result
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'sd3, -16'sd3, 1'b1);
        drain_results();
    endtask

    // distance mode: 0, 2.0, and 1.0 for both zero and orthogonal vectors
    task automatic test_distance_mode();
        write_mode(1'b1);
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh0001, 16'shffff, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, -16'sd3, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        drain_results();
    endtask

    // one long back-to-back vector of max-size pairs, large sums in all three accumulators
    task automatic test_long_vector();
        in_idle_en = 1'b0;
        for (int i = 0; i < LONG_PAIRS; i++)
            send_pair(16'sh8000, 16'sh7fff, i == LONG_PAIRS - 1);
        drain_results();
        in_idle_en = 1'b1;
    endtask

    // random vectors until the pair goal is met, with the odd full pause
    task automatic test_random_vectors(input int pair_goal);
        int start;
        start = pairs_sent;
        while (pairs_sent - start < pair_goal) begin
            send_vector(pick_length(), pick_fill());
            if ($urandom_range(19) == 0) drain_results();
        end
        drain_results();
    endtask

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit hit with %0d results outstanding",
                 $time, expected_scores.size());
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);

        test_similarity_edges();
        test_distance_mode();
        test_long_vector();

        // idling on both sides, similarity
        write_mode(1'b0);
        test_random_vectors(280);
        // long stretch with no idling at all, distance
        in_idle_en   = 1'b0;
        out_stall_en = 1'b0;
        write_mode(1'b1);
        test_random_vectors(230);
        // idling again, random mode
        in_idle_en   = 1'b1;
        out_stall_en = 1'b1;
        write_mode(1'($urandom_range(1)));
        test_random_vectors(250);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("tb_top: %0d pairs in %0d vectors (%0d with a zero vector), %0d mode writes",
                 pairs_sent, vectors_sent, zero_vectors, mode_writes);
        $display("tb_top: both score modes, extreme and long vectors, %0d results checked",
                 results_seen);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
